// ===== src/tcw_pkg.sv =====
// Shared constants for the text console character writer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam int CELL_W      = 16;
	localparam int CHAR_W      = 8;
	localparam int COLOR_W     = 8;
	localparam int ROW_FIELD_W = 5;
	localparam int COL_FIELD_W = 7;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
	localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// register index (paddr[2])
	localparam logic REG_TEXT_COLOR = 1'b0;

endpackage

`default_nettype wire

// ===== src/tcw_addr_unit.sv =====
// Shared address unit: maps a logical row/column to a memory address
// through the circular top-row offset. Two register stages. Uses tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_addr_unit #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS,
	parameter int RW      = $clog2(ROWS),
	parameter int CW      = $clog2(COLUMNS),
	parameter int AW      = $clog2(ROWS * COLUMNS)
) (
	input  wire logic          clk,
	input  wire logic [RW-1:0] row,
	input  wire logic [CW-1:0] col,
	input  wire logic [RW-1:0] top,
	output logic      [AW-1:0] addr
);
	import tcw_pkg::*;

	logic [RW:0]   sum;
	logic [RW-1:0] phys;
	logic [RW-1:0] phys_s1;
	logic [CW-1:0] col_s1;
	logic [AW-1:0] addr_s2;

	always_comb begin
		sum = {1'b0, row} + {1'b0, top};
		if (sum >= (RW+1)'(ROWS)) begin
			phys = RW'(sum - (RW+1)'(ROWS));
		end else begin
			phys = RW'(sum);
		end
	end

	always_ff @(posedge clk) begin
		phys_s1 <= phys;
		col_s1  <= col;
		addr_s2 <= AW'(phys_s1) * AW'(COLUMNS) + AW'(col_s1);
	end

	assign addr = addr_s2;

endmodule

`default_nettype wire

// ===== src/tcw_screen_mem.sv =====
// Screen cell memory, single port, registered read data.
// Uses tcw_pkg for the cell width.
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_mem #(
	parameter int DEPTH = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLUMNS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             addr,
	input  wire logic [tcw_pkg::CELL_W-1:0] wdata,
	output logic      [tcw_pkg::CELL_W-1:0] rdata
);
	import tcw_pkg::*;

	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/text_console_char_writer_unit.sv =====
// Text console character writer: sequencer, cursor, APB register, outputs.
// Instantiates tcw_addr_unit and tcw_screen_mem; uses tcw_pkg.
//
// After reset the block clears the screen with busy high. An item is taken
// when start is high and busy low; its word appears on the result ports in
// the first cycle busy is low again, with done high for one cycle, which
// cannot be held off. A new item is not taken until the last one is done. A
// put or a read goes through the address unit and the memory; a read outside
// the screen and a newline skip the memory. An item that moves past the
// bottom row also clears the bottom row, one cell per cycle through the single
// memory port. The screen scrolls by a circular row offset.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer_unit #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [tcw_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [tcw_pkg::PDATA_W-1:0]     pwdata,
	output logic      [tcw_pkg::PDATA_W-1:0]     prdata,
	output logic                                 pready,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            cmd,
	input  wire logic [tcw_pkg::CHAR_W-1:0]      char_code,
	input  wire logic [tcw_pkg::ROW_FIELD_W-1:0] read_row,
	input  wire logic [tcw_pkg::COL_FIELD_W-1:0] read_col,
	output logic                                 done,
	output logic      [tcw_pkg::CELL_W-1:0]      cell_value,
	output logic      [tcw_pkg::ROW_FIELD_W-1:0] cursor_row,
	output logic      [tcw_pkg::COL_FIELD_W-1:0] cursor_col
);
	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int AW    = $clog2(CELLS);

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_A1     = 4'd2;
	localparam logic [3:0] S_A2     = 4'd3;
	localparam logic [3:0] S_MEM    = 4'd4;
	localparam logic [3:0] S_RDW    = 4'd5;
	localparam logic [3:0] S_ADV    = 4'd6;
	localparam logic [3:0] S_B1     = 4'd7;
	localparam logic [3:0] S_B2     = 4'd8;
	localparam logic [3:0] S_CLRROW = 4'd9;
	localparam logic [3:0] S_FIN    = 4'd10;

	logic [3:0]         state_q;
	logic [COLOR_W-1:0] text_color_q;
	logic [RW-1:0]      cur_row_q;
	logic [CW-1:0]      cur_col_q;
	logic [RW-1:0]      top_q;
	logic [RW-1:0]      row_q;
	logic [CW-1:0]      col_q;
	logic               cmd_q;
	logic [CHAR_W-1:0]  char_q;
	logic [CELL_W-1:0]  cell_q;
	logic [AW-1:0]      cnt_q;
	logic               done_q;
	logic [CELL_W-1:0]  cell_value_q;
	logic [ROW_FIELD_W-1:0] cursor_row_q;
	logic [COL_FIELD_W-1:0] cursor_col_q;

	logic [AW-1:0]     unit_addr;
	logic [AW-1:0]     mem_addr;
	logic              mem_we;
	logic [CELL_W-1:0] mem_wdata;
	logic [CELL_W-1:0] mem_rdata;
	logic              accept;
	logic              in_range;
	logic              cfg_wr;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign in_range = (7'(read_row) < 7'(ROWS)) && (9'(read_col) < 9'(COLUMNS));

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TEXT_COLOR) ? PDATA_W'(text_color_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
		end else if (cfg_wr && paddr[2] == REG_TEXT_COLOR) begin
			text_color_q <= pwdata[COLOR_W-1:0];
		end
	end

	tcw_addr_unit #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS),
		.RW     (RW),
		.CW     (CW),
		.AW     (AW)
	) u_addr (
		.clk (clk),
		.row (row_q),
		.col (col_q),
		.top (top_q),
		.addr(unit_addr)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = unit_addr;
		mem_wdata = {text_color_q, SPACE_CODE};
		unique case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_addr  = cnt_q;
				mem_wdata = {RESET_COLOR, SPACE_CODE};
			end
			S_CLRROW: begin
				mem_we   = 1'b1;
				mem_addr = unit_addr + cnt_q;
			end
			S_MEM: begin
				mem_we    = (cmd_q == CMD_PUT);
				mem_wdata = {text_color_q, char_q};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	tcw_screen_mem #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			cnt_q     <= '0;
			cur_row_q <= '0;
			cur_col_q <= '0;
			top_q     <= '0;
			row_q     <= '0;
			col_q     <= '0;
			cell_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					if (cnt_q == AW'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_IDLE: begin
					if (accept) begin
						cell_q <= '0;
						if (cmd == CMD_READ) begin
							row_q   <= RW'(read_row);
							col_q   <= CW'(read_col);
							state_q <= in_range ? S_A1 : S_FIN;
						end else if (char_code == NEWLINE_CODE) begin
							cur_col_q <= '0;
							state_q   <= S_ADV;
						end else begin
							row_q   <= cur_row_q;
							col_q   <= cur_col_q;
							state_q <= S_A1;
						end
					end
				end
				S_A1: state_q <= S_A2;
				S_A2: state_q <= S_MEM;
				S_MEM: begin
					if (cmd_q == CMD_READ) begin
						state_q <= S_RDW;
					end else if (cur_col_q == CW'(COLUMNS - 1)) begin
						cur_col_q <= '0;
						state_q   <= S_ADV;
					end else begin
						cur_col_q <= cur_col_q + 1'b1;
						state_q   <= S_FIN;
					end
				end
				S_RDW: begin
					cell_q  <= mem_rdata;
					state_q <= S_FIN;
				end
				S_ADV: begin
					if (cur_row_q != RW'(ROWS - 1)) begin
						cur_row_q <= cur_row_q + 1'b1;
						state_q   <= S_FIN;
					end else begin
						top_q   <= (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
						row_q   <= RW'(ROWS - 1);
						col_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_B1;
					end
				end
				S_B1: state_q <= S_B2;
				S_B2: state_q <= S_CLRROW;
				S_CLRROW: begin
					if (cnt_q == AW'(COLUMNS - 1)) begin
						state_q <= S_FIN;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			char_q <= char_code;
		end
		if (state_q == S_FIN) begin
			cell_value_q <= cell_q;
			cursor_row_q <= ROW_FIELD_W'(cur_row_q);
			cursor_col_q <= COL_FIELD_W'(cur_col_q);
		end
	end

	assign done       = done_q;
	assign cell_value = cell_value_q;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;

endmodule

`default_nettype wire

// ===== src/tcw_checker.sv =====
// Port-level checks for text_console_char_writer_unit, bound to the top level.
// Uses tcw_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            start,
	input wire logic                            busy,
	input wire logic                            done,
	input wire logic [tcw_pkg::ROW_FIELD_W-1:0] cursor_row,
	input wire logic [tcw_pkg::COL_FIELD_W-1:0] cursor_col
);
	import tcw_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after an accepted word");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_cursor_row: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (ROWS > 32) || (int'(cursor_row) < ROWS))
		else $error("cursor row off screen");

	a_cursor_col: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (COLUMNS > 128) || (int'(cursor_col) < COLUMNS))
		else $error("cursor column off screen");

endmodule

bind text_console_char_writer_unit tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cursor_row(cursor_row),
	.cursor_col(cursor_col)
);

`default_nettype wire

// ===== sim/tb_text_console_char_writer_unit.sv =====
// Self-checking bench for text_console_char_writer_unit: directed table, then random phases.
// Predicts the screen, cursor and colour register in the bench; needs tcw_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_text_console_char_writer_unit;
	import tcw_pkg::*;

	localparam int COLUMNS     = DEF_COLUMNS;
	localparam int ROWS        = DEF_ROWS;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_WORDS = 325;
	localparam int SETTLE      = COLUMNS + 16;

	localparam logic [PADDR_W-1:0] ADDR_TEXT_COLOR = {REG_TEXT_COLOR, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_SPARE      = {~REG_TEXT_COLOR, 2'b00};
	localparam logic [CELL_W-1:0]  BLANK_CELL      = {RESET_COLOR, SPACE_CODE};

	typedef struct packed {
		logic [CELL_W-1:0]      cell_val;
		logic [ROW_FIELD_W-1:0] row;
		logic [COL_FIELD_W-1:0] col;
	} console_word_t;

	typedef struct packed {
		logic                   op;
		logic [CHAR_W-1:0]      ch;
		logic [ROW_FIELD_W-1:0] rr;
		logic [COL_FIELD_W-1:0] rc;
		logic [7:0]             reps;
		logic                   known;
		logic [CELL_W-1:0]      cell_val;
		logic [ROW_FIELD_W-1:0] row;
		logic [COL_FIELD_W-1:0] col;
	} directed_row_t;

	localparam int NUM_DIRECTED = 17;
	localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
		'{CMD_READ, 8'h00, 5'd0,  7'd0,   8'd1,  1'b1, BLANK_CELL, 5'd0,  7'd0},
		'{CMD_READ, 8'hFF, 5'd24, 7'd79,  8'd1,  1'b1, BLANK_CELL, 5'd0,  7'd0},
		'{CMD_READ, 8'h00, 5'd25, 7'd0,   8'd1,  1'b1, 16'h0000,   5'd0,  7'd0},
		'{CMD_READ, 8'h00, 5'd0,  7'd80,  8'd1,  1'b1, 16'h0000,   5'd0,  7'd0},
		'{CMD_READ, 8'hFF, 5'd31, 7'd127, 8'd1,  1'b1, 16'h0000,   5'd0,  7'd0},
		'{CMD_PUT,  8'h41, 5'd31, 7'd127, 8'd1,  1'b1, 16'h0000,   5'd0,  7'd1},
		'{CMD_PUT,  8'h00, 5'd0,  7'd0,   8'd1,  1'b1, 16'h0000,   5'd0,  7'd2},
		'{CMD_PUT,  8'hFF, 5'd0,  7'd0,   8'd1,  1'b1, 16'h0000,   5'd0,  7'd3},
		'{CMD_READ, 8'h00, 5'd0,  7'd0,   8'd1,  1'b1, 16'h0741,   5'd0,  7'd3},
		'{CMD_READ, 8'h00, 5'd0,  7'd2,   8'd1,  1'b1, 16'h07FF,   5'd0,  7'd3},
		'{CMD_PUT,  NEWLINE_CODE, 5'd0, 7'd0, 8'd1, 1'b1, 16'h0000, 5'd1, 7'd0},
		'{CMD_PUT,  NEWLINE_CODE, 5'd0, 7'd0, 8'd23, 1'b0, 16'h0000, 5'd0, 7'd0},
		'{CMD_PUT,  8'h7A, 5'd0,  7'd0,   8'd1,  1'b1, 16'h0000,   5'd24, 7'd1},
		'{CMD_PUT,  NEWLINE_CODE, 5'd0, 7'd0, 8'd1, 1'b1, 16'h0000, 5'd24, 7'd0},
		'{CMD_READ, 8'h00, 5'd23, 7'd0,   8'd1,  1'b1, 16'h077A,   5'd24, 7'd0},
		'{CMD_READ, 8'h00, 5'd24, 7'd0,   8'd1,  1'b1, BLANK_CELL, 5'd24, 7'd0},
		'{CMD_READ, 8'h00, 5'd0,  7'd0,   8'd1,  1'b1, BLANK_CELL, 5'd24, 7'd0}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [PDATA_W-1:0]     pwdata;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;
	logic                   start;
	logic                   busy;
	logic                   cmd;
	logic [CHAR_W-1:0]      char_code;
	logic [ROW_FIELD_W-1:0] read_row;
	logic [COL_FIELD_W-1:0] read_col;
	logic                   done;
	logic [CELL_W-1:0]      cell_value;
	logic [ROW_FIELD_W-1:0] cursor_row;
	logic [COL_FIELD_W-1:0] cursor_col;

	text_console_char_writer_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.char_code  (char_code),
		.read_row   (read_row),
		.read_col   (read_col),
		.done       (done),
		.cell_value (cell_value),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col)
	);

	// shadow of the screen, cursor and colour register
	logic [CELL_W-1:0]  screen_img [ROWS][COLUMNS];
	int                 text_row;
	int                 text_col;
	logic [COLOR_W-1:0] text_color_shadow;

	console_word_t pending_words [$];
	console_word_t typed_words [int];

	int mismatches;
	int cycle_count;
	int words_sent;
	int words_taken;
	int results_seen;
	int reads_taken;
	int newlines_taken;
	int scroll_count;
	int color_writes;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h (word %0d, cycle %0d)",
			what, got, want, results_seen, cycle_count);
		mismatches++;
	endtask

	function automatic void advance_line();
		if (text_row >= ROWS - 1) begin
			for (int r = 0; r < ROWS - 1; r++)
				screen_img[r] = screen_img[r + 1];
			for (int c = 0; c < COLUMNS; c++)
				screen_img[ROWS - 1][c] = {text_color_shadow, SPACE_CODE};
			text_row = ROWS - 1;
			scroll_count++;
		end else begin
			text_row++;
		end
	endfunction

	function automatic console_word_t step_console(input logic op, input logic [CHAR_W-1:0] ch,
			input logic [ROW_FIELD_W-1:0] rr, input logic [COL_FIELD_W-1:0] rc);
		console_word_t w;
		w.cell_val = '0;
		if (op == CMD_PUT) begin
			if (ch == NEWLINE_CODE) begin
				text_col = 0;
				advance_line();
			end else begin
				screen_img[text_row][text_col] = {text_color_shadow, ch};
				text_col++;
				if (text_col >= COLUMNS) begin
					text_col = 0;
					advance_line();
				end
			end
		end else if (int'(rr) < ROWS && int'(rc) < COLUMNS) begin
			w.cell_val = screen_img[rr][rc];
		end
		w.row = text_row[ROW_FIELD_W-1:0];
		w.col = text_col[COL_FIELD_W-1:0];
		return w;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_words.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result check and acceptance tracking
	always @(posedge clk) begin
		console_word_t got;
		console_word_t want;
		if (arst_n === 1'b1) begin
			if (done === 1'b1) begin
				got = '{cell_value, cursor_row, cursor_col};
				if (pending_words.size() == 0) begin
					report_mismatch("word with none pending", got, '0);
				end else begin
					want = pending_words.pop_front();
					if (got.cell_val !== want.cell_val)
						report_mismatch("cell_value", got.cell_val, want.cell_val);
					if (got.row !== want.row)
						report_mismatch("cursor_row", got.row, want.row);
					if (got.col !== want.col)
						report_mismatch("cursor_col", got.col, want.col);
				end
				results_seen++;
			end
			if (start === 1'b1 && busy === 1'b0) begin
				if (cmd == CMD_READ)
					reads_taken++;
				else if (char_code == NEWLINE_CODE)
					newlines_taken++;
				want = step_console(cmd, char_code, read_row, read_col);
				if (typed_words.exists(words_taken)) begin
					want = typed_words[words_taken];
					typed_words.delete(words_taken);
				end
				pending_words.push_back(want);
				words_taken++;
			end
		end
	end

	// call at a rising edge; returns at the edge that took the word, start still high
	task automatic send_word(input logic op, input logic [CHAR_W-1:0] ch,
			input logic [ROW_FIELD_W-1:0] rr, input logic [COL_FIELD_W-1:0] rc,
			input int idle_pct, input logic known, input console_word_t typed);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		if (known)
			typed_words[words_sent] = typed;
		words_sent++;
		start     <= 1'b1;
		cmd       <= op;
		char_code <= ch;
		read_row  <= rr;
		read_col  <= rc;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		if (addr[2] == REG_TEXT_COLOR) begin
			text_color_shadow = data[COLOR_W-1:0];
			color_writes++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_color_readback();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_TEXT_COLOR;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		if (prdata !== {{(PDATA_W-COLOR_W){1'b0}}, text_color_shadow})
			report_mismatch("text_color readback", prdata, text_color_shadow);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// lower start, drain the pending words and let a bottom-row clear finish
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	initial begin
		logic [COLOR_W-1:0]     phase_colors [4];
		int                     phase_idle [4];
		logic                   op;
		logic [CHAR_W-1:0]      ch;
		logic [ROW_FIELD_W-1:0] rr;
		logic [COL_FIELD_W-1:0] rc;
		logic [PDATA_W-1:0]     data;
		console_word_t          typed;

		phase_colors = '{8'h00, 8'hFF, COLOR_W'($urandom), COLOR_W'($urandom)};
		phase_idle   = '{0, 81, 0, 26};
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < COLUMNS; c++)
				screen_img[r][c] = BLANK_CELL;
		text_row          = 0;
		text_col          = 0;
		text_color_shadow = RESET_COLOR;

		arst_n    <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		start     <= 1'b0;
		cmd       <= CMD_PUT;
		char_code <= '0;
		read_row  <= '0;
		read_col  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// wait out the clear pass after reset
		do
			@(posedge clk);
		while (busy !== 1'b0);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			for (int k = 0; k < int'(DIRECTED[i].reps); k++) begin
				typed = '{DIRECTED[i].cell_val, DIRECTED[i].row, DIRECTED[i].col};
				send_word(DIRECTED[i].op, DIRECTED[i].ch, DIRECTED[i].rr, DIRECTED[i].rc,
					0, DIRECTED[i].known, typed);
			end
		end
		wait_idle();

		for (int p = 0; p < 4; p++) begin
			data = $urandom;
			data[COLOR_W-1:0] = phase_colors[p];
			apb_write(ADDR_TEXT_COLOR, data);
			if (p == 2)
				apb_write(ADDR_SPARE, $urandom);
			check_color_readback();
			for (int i = 0; i < PHASE_WORDS; i++) begin
				ch = $urandom;
				rr = $urandom;
				rc = $urandom;
				op = ($urandom_range(99) < 25) ? CMD_READ : CMD_PUT;
				if (op == CMD_READ && $urandom_range(9) != 0) begin
					rr = $urandom_range(ROWS - 1);
					rc = $urandom_range(COLUMNS - 1);
				end else if (op == CMD_PUT && $urandom_range(9) == 0) begin
					ch = NEWLINE_CODE;
				end
				send_word(op, ch, rr, rc, phase_idle[p], 1'b0, '0);
			end
			wait_idle();
		end

		$display("%0d words checked: %0d reads, %0d newlines, %0d scrolls",
			results_seen, reads_taken, newlines_taken, scroll_count);
		$display("%0d text color writes across idle and bursty phases", color_writes);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
